@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the stored-block PNG encoder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge outside reset
`define PSRE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle implies a condition in the next
`define PSRE_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);

`endif

@@ hw/rtl/psre_pkg.sv @@
// Types, constants and codes of the stored-block PNG encoder
`timescale 1ns / 1ps
`default_nettype none

package psre_pkg;

    localparam logic [16:0] BLOCK_MAX  = 17'd65535;
    localparam logic [16:0] ADLER_MOD  = 17'd65521;
    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [34:0] IDAT_LIMIT = 35'h07FFFFFFF;

    localparam logic [5:0] HDR_LAST  = 6'd42;
    localparam logic [5:0] BHDR_LAST = 6'd4;
    localparam logic [5:0] FOOT_LAST = 6'd19;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       image_end;
        logic       size_error;
    } out_word_t;

    typedef struct packed {
        logic       crc_en;
        logic       crc_clr;
        logic       adler_en;
        logic       adler_init;
        logic [7:0] data;
    } sum_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SIZE,
        ST_BLOCKS,
        ST_DECIDE,
        ST_ERR,
        ST_HDR,
        ST_SLOT,
        ST_BHDR,
        ST_DATA,
        ST_FOOT
    } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/psre_sum.sv @@
// Running CRC-32 and Adler-32 registers with a one-byte update unit
`timescale 1ns / 1ps
`default_nettype none

module psre_sum (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire psre_pkg::sum_ctl_t ctl,
    output logic [31:0]             crc,
    output logic [31:0]             adler
);

    logic [31:0] crc_reg, crc_next;
    logic [31:0] adler_reg, adler_next;
    logic [31:0] c;
    logic [16:0] t1, t2;
    logic [15:0] s1n, s2n;

    always_comb
    begin
        c = (ctl.crc_clr ? 32'd0 : crc_reg);
        c = ~c ^ {24'd0, ctl.data};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (psre_pkg::CRC_POLY & {32{c[0]}});
        end
        if (ctl.crc_en)
            crc_next = ~c;
        else if (ctl.crc_clr)
            crc_next = 32'd0;
        else
            crc_next = crc_reg;
    end

    // both sums stay reduced, so one subtract per add suffices
    always_comb
    begin
        t1  = {1'b0, adler_reg[15:0]} + {9'd0, ctl.data};
        s1n = (t1 >= psre_pkg::ADLER_MOD) ? 16'(t1 - psre_pkg::ADLER_MOD) : t1[15:0];
        t2  = {1'b0, adler_reg[31:16]} + {1'b0, s1n};
        s2n = (t2 >= psre_pkg::ADLER_MOD) ? 16'(t2 - psre_pkg::ADLER_MOD) : t2[15:0];
        if (ctl.adler_init)
            adler_next = 32'd1;
        else if (ctl.adler_en)
            adler_next = {s2n, s1n};
        else
            adler_next = adler_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= 32'd0;
            adler_reg <= 32'd1;
        end
        else
        begin
            crc_reg   <= crc_next;
            adler_reg <= adler_next;
        end
    end

    assign crc   = crc_reg;
    assign adler = adler_reg;

endmodule

`default_nettype wire

@@ hw/rtl/png_stored_rgb_encoder.sv @@
// Stored-block PNG encoder for 24-bit RGB pixels, top level
//
// One pixel is taken while in_stall is low; the block then holds in_stall high while
// it writes that pixel's bytes through the shared CRC/Adler unit and takes no new
// pixel until it is done. Each data byte passes a slot step and is then emitted; a
// row's filter byte leads its first pixel, and a 5-byte stored-block header leads
// each block. The first pixel of a refused frame brings an error word, and its
// dropped pixels are only counted. The first pixel of a frame adds the size arithmetic
// (ST_SIZE, ST_BLOCKS, ST_DECIDE) and, if the frame is accepted, 43 header bytes; the
// last adds 20 trailer bytes. Each byte waits in the single output register under out_stall.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module png_stored_rgb_encoder (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [14:0]          cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire psre_pkg::in_word_t   in_word,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output psre_pkg::out_word_t       out_word
);

    psre_pkg::state_t    state_reg, state_next;
    psre_pkg::out_word_t out_word_reg, emit_word;
    psre_pkg::in_word_t  pix_reg, pix_next;
    psre_pkg::sum_ctl_t  ctl;

    logic        out_valid_reg, emit;
    logic [14:0] width_reg, width_next, height_reg, height_next;
    logic [31:0] total_reg, total_next;
    logic [17:0] blocks_reg, blocks_next;
    logic [31:0] idat_reg, idat_next;
    logic        bad_reg, bad_next;
    logic [31:0] bytes_left_reg, bytes_left_next;
    logic [15:0] block_fill_reg, block_fill_next;
    logic [16:0] line_pos_reg, line_pos_next;
    logic        started_reg, started_next, failed_reg, failed_next;
    logic [5:0]  idx_reg, idx_next;
    logic [1:0]  dsel_reg, dsel_next;

    logic [31:0] crc, adler;
    logic        go, zero_size;
    logic [16:0] line_size, lp_step;
    logic [31:0] bl_dec;
    logic [16:0] bsum, brem;
    logic [1:0]  bk;
    logic [34:0] idat_full;
    logic [15:0] blk_size;
    logic [16:0] bf_inc;
    logic [7:0]  data_byte, hdr_byte, bhdr_byte, foot_byte;

    psre_sum u_sum (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .crc   (crc),
        .adler (adler)
    );

    assign go        = !out_valid_reg || !out_stall;
    assign zero_size = (width_reg == 15'd0) || (height_reg == 15'd0);
    assign line_size = {1'b0, width_reg, 1'b0} + {2'b0, width_reg} + 17'd1;
    // the filter byte counts toward the row on its first pixel
    assign lp_step   = line_pos_reg + ((line_pos_reg == 17'd0) ? 17'd4 : 17'd3);
    assign bl_dec    = bytes_left_reg - {31'd0, bytes_left_reg != 32'd0};
    assign blk_size  = (bytes_left_reg < {15'd0, psre_pkg::BLOCK_MAX}) ?
                       bytes_left_reg[15:0] : psre_pkg::BLOCK_MAX[15:0];
    assign bf_inc    = {1'b0, block_fill_reg} + 17'd1;

    // ceil(total / BLOCK_MAX): total = a*2^16 + b = a*BLOCK_MAX + (a + b)
    assign bsum = {1'b0, total_reg[31:16]} + {1'b0, total_reg[15:0]};
    always_comb
    begin
        if (bsum >= {psre_pkg::BLOCK_MAX[15:0], 1'b0})
        begin
            bk   = 2'd2;
            brem = bsum - {psre_pkg::BLOCK_MAX[15:0], 1'b0};
        end
        else if (bsum >= psre_pkg::BLOCK_MAX)
        begin
            bk   = 2'd1;
            brem = bsum - psre_pkg::BLOCK_MAX;
        end
        else
        begin
            bk   = 2'd0;
            brem = bsum;
        end
    end

    assign idat_full = {15'd0, blocks_reg, 2'b0} + {17'd0, blocks_reg} + 35'd6
                       + {3'd0, total_reg};

    always_comb
    begin
        case (dsel_reg)
            2'd0:    data_byte = 8'h00;
            2'd1:    data_byte = pix_reg.red;
            2'd2:    data_byte = pix_reg.green;
            default: data_byte = pix_reg.blue;
        endcase
    end

    always_comb
    begin
        case (idx_reg)
            6'd0:    hdr_byte = 8'h89;
            6'd1:    hdr_byte = 8'h50;
            6'd2:    hdr_byte = 8'h4E;
            6'd3:    hdr_byte = 8'h47;
            6'd4:    hdr_byte = 8'h0D;
            6'd5:    hdr_byte = 8'h0A;
            6'd6:    hdr_byte = 8'h1A;
            6'd7:    hdr_byte = 8'h0A;
            6'd11:   hdr_byte = 8'h0D;
            6'd12:   hdr_byte = 8'h49;
            6'd13:   hdr_byte = 8'h48;
            6'd14:   hdr_byte = 8'h44;
            6'd15:   hdr_byte = 8'h52;
            6'd18:   hdr_byte = {1'b0, width_reg[14:8]};
            6'd19:   hdr_byte = width_reg[7:0];
            6'd22:   hdr_byte = {1'b0, height_reg[14:8]};
            6'd23:   hdr_byte = height_reg[7:0];
            6'd24:   hdr_byte = 8'h08;
            6'd25:   hdr_byte = 8'h02;
            6'd29:   hdr_byte = crc[31:24];
            6'd30:   hdr_byte = crc[23:16];
            6'd31:   hdr_byte = crc[15:8];
            6'd32:   hdr_byte = crc[7:0];
            6'd33:   hdr_byte = idat_reg[31:24];
            6'd34:   hdr_byte = idat_reg[23:16];
            6'd35:   hdr_byte = idat_reg[15:8];
            6'd36:   hdr_byte = idat_reg[7:0];
            6'd37:   hdr_byte = 8'h49;
            6'd38:   hdr_byte = 8'h44;
            6'd39:   hdr_byte = 8'h41;
            6'd40:   hdr_byte = 8'h54;
            6'd41:   hdr_byte = 8'h08;
            6'd42:   hdr_byte = 8'h1D;
            default: hdr_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        case (idx_reg)
            6'd0:    bhdr_byte = {7'd0, bytes_left_reg <= {15'd0, psre_pkg::BLOCK_MAX}};
            6'd1:    bhdr_byte = blk_size[7:0];
            6'd2:    bhdr_byte = blk_size[15:8];
            6'd3:    bhdr_byte = ~blk_size[7:0];
            default: bhdr_byte = ~blk_size[15:8];
        endcase
    end

    always_comb
    begin
        case (idx_reg)
            6'd0:    foot_byte = adler[31:24];
            6'd1:    foot_byte = adler[23:16];
            6'd2:    foot_byte = adler[15:8];
            6'd3:    foot_byte = adler[7:0];
            6'd4:    foot_byte = crc[31:24];
            6'd5:    foot_byte = crc[23:16];
            6'd6:    foot_byte = crc[15:8];
            6'd7:    foot_byte = crc[7:0];
            6'd12:   foot_byte = 8'h49;
            6'd13:   foot_byte = 8'h45;
            6'd14:   foot_byte = 8'h4E;
            6'd15:   foot_byte = 8'h44;
            6'd16:   foot_byte = 8'hAE;
            6'd17:   foot_byte = 8'h42;
            6'd18:   foot_byte = 8'h60;
            6'd19:   foot_byte = 8'h82;
            default: foot_byte = 8'h00;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            psre_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (zero_size)
                        state_next = psre_pkg::ST_ERR;
                    else if (!started_reg)
                        state_next = psre_pkg::ST_SIZE;
                    else
                        state_next = psre_pkg::ST_SLOT;
                end
            end
            psre_pkg::ST_SIZE:   state_next = psre_pkg::ST_BLOCKS;
            psre_pkg::ST_BLOCKS: state_next = psre_pkg::ST_DECIDE;
            psre_pkg::ST_DECIDE:
                state_next = bad_next ? psre_pkg::ST_ERR : psre_pkg::ST_HDR;
            psre_pkg::ST_ERR:
            begin
                if (go)
                    state_next = started_reg ? psre_pkg::ST_SLOT : psre_pkg::ST_IDLE;
            end
            psre_pkg::ST_HDR:
            begin
                if (go && idx_reg == psre_pkg::HDR_LAST)
                    state_next = psre_pkg::ST_SLOT;
            end
            psre_pkg::ST_SLOT:
            begin
                if (failed_reg)
                    state_next = (dsel_reg == 2'd3) ? psre_pkg::ST_IDLE : psre_pkg::ST_SLOT;
                else if (block_fill_reg == 16'd0)
                    state_next = psre_pkg::ST_BHDR;
                else
                    state_next = psre_pkg::ST_DATA;
            end
            psre_pkg::ST_BHDR:
            begin
                if (go && idx_reg == psre_pkg::BHDR_LAST)
                    state_next = psre_pkg::ST_DATA;
            end
            psre_pkg::ST_DATA:
            begin
                if (go)
                begin
                    if (dsel_reg != 2'd3)
                        state_next = psre_pkg::ST_SLOT;
                    else if (bl_dec == 32'd0)
                        state_next = psre_pkg::ST_FOOT;
                    else
                        state_next = psre_pkg::ST_IDLE;
                end
            end
            psre_pkg::ST_FOOT:
            begin
                if (go && idx_reg == psre_pkg::FOOT_LAST)
                    state_next = psre_pkg::ST_IDLE;
            end
            default: state_next = psre_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        emit            = 1'b0;
        emit_word       = '0;
        ctl             = '0;
        pix_next        = pix_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        total_next      = total_reg;
        blocks_next     = blocks_reg;
        idat_next       = idat_reg;
        bad_next        = bad_reg;
        bytes_left_next = bytes_left_reg;
        block_fill_next = block_fill_reg;
        line_pos_next   = line_pos_reg;
        started_next    = started_reg;
        failed_next     = failed_reg;
        idx_next        = idx_reg;
        dsel_next       = dsel_reg;

        case (state_reg)
            psre_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    pix_next  = in_word;
                    dsel_next = (line_pos_reg == 17'd0) ? 2'd0 : 2'd1;
                end
            end
            psre_pkg::ST_SIZE:
                total_next = 32'({15'd0, line_size} * {17'd0, height_reg});
            psre_pkg::ST_BLOCKS:
                blocks_next = {2'd0, total_reg[31:16]} + {16'd0, bk}
                              + {17'd0, brem != 17'd0};
            psre_pkg::ST_DECIDE:
            begin
                bad_next = (idat_full > psre_pkg::IDAT_LIMIT) ||
                           (width_reg == 15'd1 && height_reg == 15'd1);
                idat_next       = idat_full[31:0];
                ctl.crc_clr     = 1'b1;
                ctl.adler_init  = 1'b1;
                block_fill_next = 16'd0;
                line_pos_next   = 17'd0;
                bytes_left_next = total_reg;
                started_next    = 1'b1;
                failed_next     = bad_next;
                idx_next        = 6'd0;
                dsel_next       = 2'd0;
            end
            psre_pkg::ST_ERR:
            begin
                if (go)
                begin
                    emit                 = 1'b1;
                    emit_word.run_last   = 1'b1;
                    emit_word.size_error = 1'b1;
                end
            end
            psre_pkg::ST_HDR:
            begin
                if (go)
                begin
                    emit               = 1'b1;
                    emit_word.out_byte = hdr_byte;
                    ctl.data           = hdr_byte;
                    ctl.crc_en  = (idx_reg >= 6'd12 && idx_reg <= 6'd28) || idx_reg >= 6'd37;
                    ctl.crc_clr = (idx_reg == 6'd12) || (idx_reg == 6'd37);
                    idx_next    = (idx_reg == psre_pkg::HDR_LAST) ? 6'd0 : idx_reg + 6'd1;
                end
            end
            psre_pkg::ST_SLOT:
            begin
                idx_next = 6'd0;
                if (failed_reg)
                begin
                    // drop the byte, only count it
                    bytes_left_next = bl_dec;
                    if (dsel_reg == 2'd3)
                    begin
                        line_pos_next = (lp_step >= line_size) ? 17'd0 : lp_step;
                        if (bl_dec == 32'd0)
                        begin
                            started_next = 1'b0;
                            failed_next  = 1'b0;
                        end
                    end
                    else
                        dsel_next = dsel_reg + 2'd1;
                end
            end
            psre_pkg::ST_BHDR:
            begin
                if (go)
                begin
                    emit               = 1'b1;
                    emit_word.out_byte = bhdr_byte;
                    ctl.data           = bhdr_byte;
                    ctl.crc_en         = 1'b1;
                    idx_next = (idx_reg == psre_pkg::BHDR_LAST) ? 6'd0 : idx_reg + 6'd1;
                end
            end
            psre_pkg::ST_DATA:
            begin
                if (go)
                begin
                    emit               = 1'b1;
                    emit_word.out_byte = data_byte;
                    emit_word.run_last = (dsel_reg == 2'd3) && (bl_dec != 32'd0);
                    ctl.data           = data_byte;
                    ctl.crc_en         = 1'b1;
                    ctl.adler_en       = 1'b1;
                    bytes_left_next    = bl_dec;
                    block_fill_next = (bf_inc >= psre_pkg::BLOCK_MAX) ? 16'd0 : bf_inc[15:0];
                    idx_next        = 6'd0;
                    if (dsel_reg == 2'd3)
                        line_pos_next = (lp_step >= line_size) ? 17'd0 : lp_step;
                    else
                        dsel_next = dsel_reg + 2'd1;
                end
            end
            psre_pkg::ST_FOOT:
            begin
                if (go)
                begin
                    emit               = 1'b1;
                    emit_word.out_byte = foot_byte;
                    ctl.data           = foot_byte;
                    ctl.crc_en         = (idx_reg < 6'd4);
                    if (idx_reg == psre_pkg::FOOT_LAST)
                    begin
                        emit_word.run_last  = 1'b1;
                        emit_word.image_end = 1'b1;
                        started_next        = 1'b0;
                        failed_next         = 1'b0;
                        idx_next            = 6'd0;
                    end
                    else
                        idx_next = idx_reg + 6'd1;
                end
            end
            default: ;
        endcase

        // any register write abandons the frame
        if (cfg_write)
        begin
            if (cfg_index == psre_pkg::CFG_WIDTH)
                width_next = cfg_data;
            else if (cfg_index == psre_pkg::CFG_HEIGHT)
                height_next = cfg_data;
            started_next    = 1'b0;
            failed_next     = 1'b0;
            bytes_left_next = 32'd0;
            block_fill_next = 16'd0;
            line_pos_next   = 17'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= psre_pkg::ST_IDLE;
            out_valid_reg  <= 1'b0;
            width_reg      <= 15'd1;
            height_reg     <= 15'd1;
            bytes_left_reg <= 32'd0;
            block_fill_reg <= 16'd0;
            line_pos_reg   <= 17'd0;
            started_reg    <= 1'b0;
            failed_reg     <= 1'b0;
            idx_reg        <= 6'd0;
            dsel_reg       <= 2'd0;
        end
        else
        begin
            state_reg      <= state_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            bytes_left_reg <= bytes_left_next;
            block_fill_reg <= block_fill_next;
            line_pos_reg   <= line_pos_next;
            started_reg    <= started_next;
            failed_reg     <= failed_next;
            idx_reg        <= idx_next;
            dsel_reg       <= dsel_next;
            if (go)
                out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg    <= pix_next;
        total_reg  <= total_next;
        blocks_reg <= blocks_next;
        idat_reg   <= idat_next;
        bad_reg    <= bad_next;
        if (go)
            out_word_reg <= emit_word;
    end

    assign in_stall  = (state_reg != psre_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    `PSRE_ASSERT(a_err_word, out_valid && out_word.size_error |-> out_word.run_last && !out_word.image_end && out_word.out_byte == 8'h00, "error word malformed")
    `PSRE_ASSERT(a_foot_live, state_reg == psre_pkg::ST_FOOT |-> !failed_reg && started_reg, "trailer in a dropped frame")
    `PSRE_ASSERT(a_adler_range, adler[15:0] < psre_pkg::ADLER_MOD[15:0] && adler[31:16] < psre_pkg::ADLER_MOD[15:0], "adler sum not reduced")
    `PSRE_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "pixel taken but block not busy")

endmodule

`default_nettype wire
